// File: sv/websocket_fragment_reassembler_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the websocket fragment reassembler
// Clocked implication forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAGMENT_REASSEMBLER_TOP_MACROS_SVH
`define WEBSOCKET_FRAGMENT_REASSEMBLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WSFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsfr assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WSFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsfr assertion failed");

`endif

// File: sv/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Field layout, opcodes and status codes of the fragment reassembler.
// ----------------------------------------------------------------------------
package wsfr_pkg;

    localparam int OP_W    = 4;
    localparam int SIZE_W  = 13;
    localparam int BYTE_W  = 8;
    localparam int OFF_W   = 12;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;

    // Input tdata layout, lowest bit first
    localparam int S_OP_LO    = 0;
    localparam int S_FIN_LO   = S_OP_LO + OP_W;
    localparam int S_FSIZE_LO = S_FIN_LO + 1;
    localparam int S_LEN_LO   = S_FSIZE_LO + SIZE_W;
    localparam int S_BYTE_LO  = S_LEN_LO + SIZE_W;
    localparam int S_USED_W   = S_BYTE_LO + BYTE_W;
    localparam int S_DATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first
    localparam int M_WV_LO    = 0;
    localparam int M_OFF_LO   = M_WV_LO + 1;
    localparam int M_BYTE_LO  = M_OFF_LO + OFF_W;
    localparam int M_STAT_LO  = M_BYTE_LO + BYTE_W;
    localparam int M_KIND_LO  = M_STAT_LO + STAT_W;
    localparam int M_LEN_LO   = M_KIND_LO + KIND_W;
    localparam int M_USED_W   = M_LEN_LO + SIZE_W;
    localparam int M_DATA_W   = ((M_USED_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_CONT      = 4'd0;
    localparam logic [OP_W-1:0] OP_TEXT      = 4'd1;
    localparam logic [OP_W-1:0] OP_BINARY    = 4'd2;
    localparam logic [OP_W-1:0] OP_CTRL_LO   = 4'd8;
    localparam logic [OP_W-1:0] OP_CTRL_HI   = 4'd10;

    localparam logic [SIZE_W-1:0] CTRL_MAX_BYTES = 13'd125;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;

    typedef enum logic [STAT_W-1:0] {
        ST_MID      = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

endpackage

// File: sv/websocket_fragment_reassembler_top.sv
// ----------------------------------------------------------------------------
// websocket_fragment_reassembler_top
// Reassembles websocket message fragments one payload byte per item.
// ----------------------------------------------------------------------------
// Each input item carries one payload byte plus the header facts of the frame
// it belongs to. The first item of a chunk (s_tuser) judges the whole chunk:
// control frames (opcodes 8 to 10) pass with fin set and at most 125 bytes and
// are never stored; text and binary frames open a message, continuations
// extend one that still expects more. Accepted bytes leave with their message
// offset; the item flagged s_tlast reports accepted, complete or rejected, and
// the bytes of a rejected chunk are dropped. Every input item yields exactly
// one result item. Throughput is one item per cycle while the output does not
// stall. The block has two register stages: an input register feeds a single
// stage of compare and add logic that updates the reassembly state and loads
// the result register, whose valid bit drives m_tvalid. With both
// registers full, s_tready falls in the same cycle as m_tready; an empty input
// register still takes one item while a result waits. MESSAGE_CAPACITY
// bounds the message size and sets the width of the byte counter; offsets and
// lengths on the output are the low bits of that counter.
// ----------------------------------------------------------------------------
module websocket_fragment_reassembler_top #(
    parameter int MESSAGE_CAPACITY = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode[3:0], fin[4], frame_bytes[17:5], chunk_length[30:18],
    // payload_byte[38:31], zero fill above
    input  logic [wsfr_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,   // last_of_chunk
    input  logic                          s_tuser,   // first_of_chunk
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // write_valid[0], write_offset[12:1], write_byte[20:13], status[22:21],
    // message_kind[24:23], message_length[37:25], zero fill above
    output logic [wsfr_pkg::M_DATA_W-1:0] m_tdata
);
    import wsfr_pkg::*;

    localparam int CNT_W = $clog2(MESSAGE_CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(MESSAGE_CAPACITY);

    // Input register
    logic              in_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic              fin_reg;
    logic [SIZE_W-1:0] fsize_reg;
    logic [SIZE_W-1:0] len_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              first_reg;
    logic              last_reg;

    // Reassembly state
    logic              inside_frame_reg, inside_frame_next;
    logic              expect_more_reg, expect_more_next;
    logic [CNT_W-1:0]  gathered_reg, gathered_next;
    logic [SIZE_W-1:0] cur_fsize_reg, cur_fsize_next;
    logic [SIZE_W-1:0] progress_reg, progress_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              drop_rest_reg, drop_rest_next;
    logic              chunk_open_reg, chunk_open_next;
    logic [SIZE_W-1:0] chunk_left_reg, chunk_left_next;
    logic              chunk_fin_reg, chunk_fin_next;
    logic              chunk_ctrl_reg, chunk_ctrl_next;

    // Result register
    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg, out_data_next;

    logic advance;
    logic ok;
    logic wv;
    logic [OFF_W-1:0] woff;
    logic [BYTE_W-1:0] wbyte;
    status_t status;
    logic [CMP_W-1:0] gathered_wide;
    logic [CMP_W-1:0] room;
    logic [CMP_W-1:0] len_wide;
    logic [CMP_W-1:0] fsize_wide;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign len_wide   = CMP_W'(len_reg);
    assign fsize_wide = CMP_W'(fsize_reg);

    always_comb
    begin
        inside_frame_next = inside_frame_reg;
        expect_more_next  = expect_more_reg;
        gathered_next     = gathered_reg;
        cur_fsize_next    = cur_fsize_reg;
        progress_next     = progress_reg;
        kind_next         = kind_reg;
        drop_rest_next    = drop_rest_reg;
        chunk_open_next   = chunk_open_reg;
        chunk_left_next   = chunk_left_reg;
        chunk_fin_next    = chunk_fin_reg;
        chunk_ctrl_next   = chunk_ctrl_reg;
        ok                = 1'b1;
        room              = '0;
        wv                = 1'b0;
        woff              = '0;
        wbyte             = '0;
        status            = ST_MID;
        gathered_wide     = '0;

        // Judge the whole chunk on its first item
        if (first_reg)
        begin
            chunk_open_next = 1'b1;
            chunk_fin_next  = fin_reg;
            chunk_left_next = '0;
            if (op_reg >= OP_CTRL_LO)
            begin
                chunk_ctrl_next = 1'b1;
                ok = (op_reg <= OP_CTRL_HI) && fin_reg && (fsize_reg <= CTRL_MAX_BYTES);
            end
            else
            begin
                chunk_ctrl_next = 1'b0;
                if (!inside_frame_reg)
                begin
                    if (op_reg == OP_TEXT || op_reg == OP_BINARY)
                    begin
                        if (expect_more_reg)
                        begin
                            ok = 1'b0;
                        end
                        else
                        begin
                            gathered_next = '0;
                            kind_next     = op_reg[KIND_W-1:0];
                        end
                    end
                    else if (op_reg != OP_CONT || !expect_more_reg)
                    begin
                        ok = 1'b0;
                    end
                    if (ok)
                    begin
                        room = CAP_C - CMP_W'(gathered_next);
                        if (fsize_wide > room)
                        begin
                            ok = 1'b0;
                        end
                        else
                        begin
                            cur_fsize_next    = fsize_reg;
                            progress_next     = '0;
                            inside_frame_next = 1'b1;
                        end
                    end
                end
                if (ok)
                begin
                    room = CAP_C - CMP_W'(gathered_next);
                    if (fsize_reg != cur_fsize_next)
                        ok = 1'b0;
                    else if (len_reg > (cur_fsize_next - progress_next))
                        ok = 1'b0;
                    else if (len_wide > room)
                        ok = 1'b0;
                end
            end
            if (ok)
            begin
                drop_rest_next = 1'b0;
                if (!chunk_ctrl_next)
                    chunk_left_next = len_reg;
            end
            else
            begin
                drop_rest_next = 1'b1;
            end
        end

        // Store the byte while the accepted chunk has bytes left
        if (chunk_open_next && !drop_rest_next && !chunk_ctrl_next && chunk_left_next != '0)
        begin
            gathered_wide   = CMP_W'(gathered_next);
            wv              = 1'b1;
            woff            = gathered_wide[OFF_W-1:0];
            wbyte           = byte_reg;
            gathered_next   = gathered_next + 1'b1;
            progress_next   = progress_next + 1'b1;
            chunk_left_next = chunk_left_next - 1'b1;
        end

        // Report the verdict on the last item and close the chunk
        if (last_reg)
        begin
            if (!chunk_open_next || drop_rest_next)
                status = ST_REJECTED;
            else if (chunk_ctrl_next)
                status = ST_ACCEPTED;
            else if (progress_next != cur_fsize_next)
                status = ST_ACCEPTED;
            else
            begin
                inside_frame_next = 1'b0;
                expect_more_next  = !chunk_fin_next;
                status            = chunk_fin_next ? ST_COMPLETE : ST_ACCEPTED;
            end
            chunk_open_next = 1'b0;
            chunk_left_next = '0;
            drop_rest_next  = 1'b0;
            chunk_ctrl_next = 1'b0;
        end

        gathered_wide = CMP_W'(gathered_next);
        out_data_next = '0;
        out_data_next[M_WV_LO]                    = wv;
        out_data_next[M_OFF_LO +: OFF_W]          = woff;
        out_data_next[M_BYTE_LO +: BYTE_W]        = wbyte;
        out_data_next[M_STAT_LO +: STAT_W]        = status;
        out_data_next[M_KIND_LO +: KIND_W]        = kind_next;
        out_data_next[M_LEN_LO +: SIZE_W]         = gathered_wide[SIZE_W-1:0];
    end

    // Input register: take an item whenever the stage below frees up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg    <= s_tdata[S_OP_LO +: OP_W];
            fin_reg   <= s_tdata[S_FIN_LO];
            fsize_reg <= s_tdata[S_FSIZE_LO +: SIZE_W];
            len_reg   <= s_tdata[S_LEN_LO +: SIZE_W];
            byte_reg  <= s_tdata[S_BYTE_LO +: BYTE_W];
            first_reg <= s_tuser;
            last_reg  <= s_tlast;
        end
    end

    // State and result register: advance when the result slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            inside_frame_reg <= 1'b0;
            expect_more_reg  <= 1'b0;
            gathered_reg     <= '0;
            cur_fsize_reg    <= '0;
            progress_reg     <= '0;
            kind_reg         <= KIND_NONE;
            drop_rest_reg    <= 1'b0;
            chunk_open_reg   <= 1'b0;
            chunk_left_reg   <= '0;
            chunk_fin_reg    <= 1'b0;
            chunk_ctrl_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                inside_frame_reg <= inside_frame_next;
                expect_more_reg  <= expect_more_next;
                gathered_reg     <= gathered_next;
                cur_fsize_reg    <= cur_fsize_next;
                progress_reg     <= progress_next;
                kind_reg         <= kind_next;
                drop_rest_reg    <= drop_rest_next;
                chunk_open_reg   <= chunk_open_next;
                chunk_left_reg   <= chunk_left_next;
                chunk_fin_reg    <= chunk_fin_next;
                chunk_ctrl_reg   <= chunk_ctrl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: sv/wsfr_checker.sv
// ----------------------------------------------------------------------------
// wsfr_checker
// Port-level checks of the fragment reassembler, bound to the top level.
// ----------------------------------------------------------------------------
`include "websocket_fragment_reassembler_top_macros.svh"

module wsfr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wsfr_pkg::M_DATA_W-1:0] m_tdata
);
    import wsfr_pkg::*;

    logic              wv;
    logic [OFF_W-1:0]  woff;
    logic [OFF_W-1:0]  len_low;
    logic [KIND_W-1:0] kind;

    assign wv      = m_tdata[M_WV_LO];
    assign woff    = m_tdata[M_OFF_LO +: OFF_W];
    assign len_low = m_tdata[M_LEN_LO +: OFF_W];
    assign kind    = m_tdata[M_KIND_LO +: KIND_W];

    // A stored byte is the last one counted in the message length
    `WSFR_ASSERT_IMP(a_offset_len, m_tvalid && wv, len_low == woff + 1'b1)
    // Bytes are stored only inside a text or binary message
    `WSFR_ASSERT_IMP(a_kind_set, m_tvalid && wv, kind != KIND_NONE)
    // A waiting result holds its payload
    `WSFR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // With the result slot free, the input side is ready
    `WSFR_ASSERT_IMP(a_ready, !m_tvalid, s_tready)

endmodule

bind websocket_fragment_reassembler_top wsfr_checker u_wsfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
